@@ sv/lhist_pkg.sv @@
package lhist_pkg;

    localparam logic [1:0] CMD_RECORD    = 2'd0;
    localparam logic [1:0] CMD_SUMMARIZE = 2'd1;
    localparam logic [1:0] CMD_CLEAR     = 2'd2;

    localparam logic [63:0] US_DIVISOR = 64'd1000;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rec_lookup;
        logic rec_update;
        logic clear;
        logic sum_start;
        logic walk_rd;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic walk_busy;
    } t_dp_status;

endpackage

@@ sv/lhist_div.sv @@
module lhist_div
    import lhist_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [64:0] rem_sh;
    logic        fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem[63:0], r_quo[63]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[62:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ sv/lhist_ctrl.sv @@
module lhist_ctrl
    import lhist_pkg::*;
#(
    parameter int NUM_BUCKETS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [1:0]                     i_cmd,
    input  t_dp_status                     i_status,
    output t_dp_cmd                        o_cmd,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_walk_addr,
    output logic                           busy,
    output logic                           o_valid
);

    localparam int BW = $clog2(NUM_BUCKETS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REC_RD = 3'd1;
    localparam logic [2:0] S_REC_WR = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [BW-1:0] r_addr, n_addr;
    logic          take;

    assign take = start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = take;
                if (take) begin
                    unique case (i_cmd)
                        CMD_RECORD:    n_state = S_REC_RD;
                        CMD_SUMMARIZE: begin
                            n_state         = S_WALK;
                            n_addr          = '0;
                            o_cmd.sum_start = 1'b1;
                        end
                        CMD_CLEAR:     o_cmd.clear = 1'b1;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_REC_RD: begin
                o_cmd.rec_lookup = 1'b1;
                n_state          = S_REC_WR;
            end
            S_REC_WR: begin
                o_cmd.rec_update = 1'b1;
                n_state          = S_IDLE;
            end
            S_WALK: begin
                o_cmd.walk_rd = 1'b1;
                n_addr        = r_addr + BW'(1);
                if (r_addr == BW'(NUM_BUCKETS - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_status.div_done && !i_status.walk_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_walk_addr = r_addr;
    assign busy        = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);

endmodule

@@ sv/lhist_dp.sv @@
module lhist_dp
    import lhist_pkg::*;
#(
    parameter int NUM_BUCKETS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    input  logic [$clog2(NUM_BUCKETS)-1:0] i_walk_addr,
    input  logic [63:0]                    i_latency_ns,
    output t_dp_status                     o_status,
    output logic [63:0]                    o_sample_count,
    output logic [63:0]                    o_mean_ns,
    output logic [63:0]                    o_smallest_ns,
    output logic [63:0]                    o_largest_ns,
    output logic [63:0]                    o_median_bound_ns,
    output logic [63:0]                    o_p99_bound_ns,
    output logic [63:0]                    o_p999_bound_ns
);

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int CW = 64 + $clog2(NUM_BUCKETS);
    localparam int PW = CW + 10;

    logic [63:0] mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_vld;

    logic [63:0]   r_ns;
    logic [BW-1:0] r_bidx;
    logic [BW-1:0] bidx_c;
    logic [63:0]   r_rd_data;
    logic          r_rd_hit;
    logic [63:0]   word;
    logic [BW-1:0] rd_addr;
    logic          rd_en;

    logic [63:0] r_total, r_sum, r_min, r_max, r_mean;
    logic [PW-1:0] r_t99, r_t999;
    logic [CW-1:0] r_cum;
    logic          r_b_valid, r_c_valid, r_div_done;
    logic [BW-1:0] r_b_idx, r_c_idx;
    logic          r_f50, r_f99, r_f999;
    logic [63:0]   r_b50, r_b99, r_b999;
    logic [PW-1:0] cum2, cum100, cum1000;
    logic [63:0]   upper;
    logic          hit50, hit99, hit999;
    logic          div_done;
    logic [63:0]   quotient;

    // us >= 2^k exactly when ns >= 1000 * 2^k
    always_comb begin
        bidx_c = '0;
        for (int k = 1; k < NUM_BUCKETS; k++) begin
            if (r_ns >= (US_DIVISOR << k)) begin
                bidx_c = BW'(k);
            end
        end
    end

    assign rd_addr = i_cmd.walk_rd ? i_walk_addr : bidx_c;
    assign rd_en   = i_cmd.walk_rd || i_cmd.rec_lookup;
    assign word    = r_rd_hit ? r_rd_data : 64'd0;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.rec_update) begin
            mem[r_bidx] <= word + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_hit <= r_vld[rd_addr];
            end
            if (i_cmd.clear) begin
                r_vld <= '0;
            end else if (i_cmd.rec_update) begin
                r_vld[r_bidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ns <= i_latency_ns;
        end
        if (i_cmd.rec_lookup) begin
            r_bidx <= bidx_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_total <= '0;
            r_sum   <= '0;
            r_min   <= ALL_ONES;
            r_max   <= '0;
        end else if (i_cmd.rec_update) begin
            r_total <= r_total + 64'd1;
            r_sum   <= r_sum + r_ns;
            if (r_ns < r_min) r_min <= r_ns;
            if (r_ns > r_max) r_max <= r_ns;
        end
    end

    // percentile tests, reduced: 2c >= t, 100c >= 99t, 1000c >= 999t
    assign cum2    = PW'(r_cum) << 1;
    assign cum100  = PW'(r_cum) * PW'(100);
    assign cum1000 = PW'(r_cum) * PW'(1000);
    assign hit50   = cum2 >= PW'(r_total);
    assign hit99   = cum100 >= r_t99;
    assign hit999  = cum1000 >= r_t999;
    assign upper   = (r_c_idx == BW'(NUM_BUCKETS - 1)) ? ALL_ONES
                                                       : (64'd2000 << r_c_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_b_valid <= i_cmd.walk_rd;
            r_c_valid <= r_b_valid;
            if (i_cmd.sum_start) begin
                r_div_done <= 1'b0;
            end else if (div_done) begin
                r_div_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_idx <= i_walk_addr;
        r_c_idx <= r_b_idx;
        if (div_done) begin
            r_mean <= quotient;
        end
        if (i_cmd.sum_start) begin
            r_cum  <= '0;
            r_t99  <= PW'(r_total) * PW'(99);
            r_t999 <= PW'(r_total) * PW'(999);
            r_f50  <= 1'b0;
            r_f99  <= 1'b0;
            r_f999 <= 1'b0;
            r_b50  <= '0;
            r_b99  <= '0;
            r_b999 <= '0;
        end else begin
            if (r_b_valid) begin
                r_cum <= r_cum + CW'(word);
            end
            if (r_c_valid && (r_total != 64'd0)) begin
                if (!r_f50 && hit50) begin
                    r_f50 <= 1'b1;
                    r_b50 <= upper;
                end
                if (!r_f99 && hit99) begin
                    r_f99 <= 1'b1;
                    r_b99 <= upper;
                end
                if (!r_f999 && hit999) begin
                    r_f999 <= 1'b1;
                    r_b999 <= upper;
                end
            end
        end
    end

    lhist_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sum_start),
        .i_dividend (r_sum),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign o_status.div_done  = r_div_done;
    assign o_status.walk_busy = r_b_valid || r_c_valid;

    assign o_sample_count    = r_total;
    assign o_mean_ns         = (r_total != 64'd0) ? r_mean : 64'd0;
    assign o_smallest_ns     = (r_total != 64'd0) ? r_min : 64'd0;
    assign o_largest_ns      = r_max;
    assign o_median_bound_ns = r_b50;
    assign o_p99_bound_ns    = r_b99;
    assign o_p999_bound_ns   = r_b999;

endmodule

@@ sv/log2_latency_histogram_core.sv @@
// Record: accept, then lookup and read in S_REC_RD, write back in S_REC_WR, then the next accept.
// Clear and unused commands: handled at accept with no further states; no result.
// Summarize: the result strobe waits on the 64-step bit-serial divider for the mean; the
// bucket walk runs beside it.
// Reset (i_rst_n low, synchronous) empties the histogram at once via per-bucket valid bits.
// The result is shown for one cycle on o_valid; the receiver cannot stall.
module log2_latency_histogram_core
    import lhist_pkg::*;
#(
    parameter int NUM_BUCKETS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_latency_ns,
    output logic        o_valid,
    output logic [63:0] o_sample_count,
    output logic [63:0] o_mean_ns,
    output logic [63:0] o_smallest_ns,
    output logic [63:0] o_largest_ns,
    output logic [63:0] o_median_bound_ns,
    output logic [63:0] o_p99_bound_ns,
    output logic [63:0] o_p999_bound_ns
);

    localparam int BW = $clog2(NUM_BUCKETS);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic [BW-1:0] walk_addr;

    // sequence each item: decode the command, step the bucket walk, wait for the mean
    lhist_ctrl #(.NUM_BUCKETS(NUM_BUCKETS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_walk_addr (walk_addr),
        .busy        (busy),
        .o_valid     (o_valid)
    );

    // hold bucket memory, totals, extremes, percentile search and divider
    lhist_dp #(.NUM_BUCKETS(NUM_BUCKETS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_walk_addr       (walk_addr),
        .i_latency_ns      (i_latency_ns),
        .o_status          (dp_status),
        .o_sample_count    (o_sample_count),
        .o_mean_ns         (o_mean_ns),
        .o_smallest_ns     (o_smallest_ns),
        .o_largest_ns      (o_largest_ns),
        .o_median_bound_ns (o_median_bound_ns),
        .o_p99_bound_ns    (o_p99_bound_ns),
        .o_p999_bound_ns   (o_p999_bound_ns)
    );

`ifndef NO_ASSERTIONS
    // a result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    // a result only comes while a summarize item is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    // an accepted record item keeps the block busy for its write back
    a_record_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_RECORD) |=> busy ##1 busy)
        else $error("record item dropped early");
`endif

endmodule

@@ tb/lhist_checker.sv @@
module lhist_checker
    import lhist_pkg::*;
#(
    parameter int NUM_BUCKETS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_latency_ns,
    input  logic        o_valid,
    input  logic [63:0] o_sample_count,
    input  logic [63:0] o_mean_ns,
    input  logic [63:0] o_smallest_ns,
    input  logic [63:0] o_largest_ns,
    input  logic [63:0] o_median_bound_ns,
    input  logic [63:0] o_p99_bound_ns,
    input  logic [63:0] o_p999_bound_ns,
    output int          fail_count,
    output int          summaries_pending
);

    typedef struct packed {
        logic [63:0] count;
        logic [63:0] mean;
        logic [63:0] smallest;
        logic [63:0] largest;
        logic [63:0] p50;
        logic [63:0] p99;
        logic [63:0] p999;
    } t_summary;

    logic [63:0] hist_bins [NUM_BUCKETS];
    logic [63:0] hist_total;
    logic [63:0] hist_sum;
    logic [63:0] hist_min;
    logic [63:0] hist_max;
    t_summary    summary_q[$];

    function automatic int bin_of(logic [63:0] ns);
        logic [63:0] us;
        int lg;
        us = ns / US_DIVISOR;
        lg = 0;
        while (us > 1) begin
            us = us >> 1;
            lg++;
        end
        return (lg > NUM_BUCKETS - 1) ? NUM_BUCKETS - 1 : lg;
    endfunction

    function automatic t_summary summarize_hist();
        t_summary s;
        logic [127:0] cum;
        logic [63:0] upper;
        bit f50, f99, f999;
        s = '0;
        f50 = 0;
        f99 = 0;
        f999 = 0;
        cum = '0;
        s.count    = hist_total;
        s.mean     = (hist_total != 0) ? hist_sum / hist_total : 64'd0;
        s.smallest = (hist_total != 0) ? hist_min : 64'd0;
        s.largest  = hist_max;
        if (hist_total == 0) return s;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            cum = cum + {64'd0, hist_bins[i]};
            upper = (i < NUM_BUCKETS - 1) ? (64'd1 << (i + 1)) * 64'd1000 : ALL_ONES;
            // exact wide compares; totals never overflow 128 bits
            if (!f50 && cum * 128'd1000 >= {64'd0, hist_total} * 128'd500) begin
                s.p50 = upper;
                f50 = 1;
            end
            if (!f99 && cum * 128'd1000 >= {64'd0, hist_total} * 128'd990) begin
                s.p99 = upper;
                f99 = 1;
            end
            if (!f999 && cum * 128'd10000 >= {64'd0, hist_total} * 128'd9990) begin
                s.p999 = upper;
                f999 = 1;
            end
        end
        return s;
    endfunction

    task automatic clear_hist();
        for (int i = 0; i < NUM_BUCKETS; i++) hist_bins[i] = '0;
        hist_total = '0;
        hist_sum = '0;
        hist_min = ALL_ONES;
        hist_max = '0;
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        clear_hist();
    end

    assign summaries_pending = summary_q.size();

    always @(posedge i_clk) begin
        t_summary w;
        if (!i_rst_n) begin
            clear_hist();
            summary_q.delete();
        end else begin
            if (o_valid) begin
                if (summary_q.size() == 0) begin
                    report("unexpected summary", o_sample_count, 64'd0);
                end else begin
                    w = summary_q.pop_front();
                    if (o_sample_count !== w.count) report("count", o_sample_count, w.count);
                    if (o_mean_ns !== w.mean) report("mean", o_mean_ns, w.mean);
                    if (o_smallest_ns !== w.smallest)
                        report("smallest", o_smallest_ns, w.smallest);
                    if (o_largest_ns !== w.largest) report("largest", o_largest_ns, w.largest);
                    if (o_median_bound_ns !== w.p50) report("p50", o_median_bound_ns, w.p50);
                    if (o_p99_bound_ns !== w.p99) report("p99", o_p99_bound_ns, w.p99);
                    if (o_p999_bound_ns !== w.p999) report("p999", o_p999_bound_ns, w.p999);
                end
            end
            if (start && !busy) begin
                case (i_cmd)
                    CMD_RECORD: begin
                        hist_bins[bin_of(i_latency_ns)] += 64'd1;
                        hist_total += 64'd1;
                        hist_sum += i_latency_ns;
                        if (i_latency_ns < hist_min) hist_min = i_latency_ns;
                        if (i_latency_ns > hist_max) hist_max = i_latency_ns;
                    end
                    CMD_SUMMARIZE: summary_q.push_back(summarize_hist());
                    CMD_CLEAR: clear_hist();
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ tb/tb_log2_latency_histogram_core.sv @@
module tb_log2_latency_histogram_core;
    import lhist_pkg::*;

    localparam int NUM_BUCKETS = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // room for the last summary to finish, with margin on top
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [63:0] i_latency_ns;
    logic        o_valid;
    logic [63:0] o_sample_count;
    logic [63:0] o_mean_ns;
    logic [63:0] o_smallest_ns;
    logic [63:0] o_largest_ns;
    logic [63:0] o_median_bound_ns;
    logic [63:0] o_p99_bound_ns;
    logic [63:0] o_p999_bound_ns;
    int          fail_count;
    int          summaries_pending;
    int          cycle_count;
    int          idle_left;
    bit          idle_enable;

    log2_latency_histogram_core #(.NUM_BUCKETS(NUM_BUCKETS)) dut (.*);

    lhist_checker #(.NUM_BUCKETS(NUM_BUCKETS)) checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Bound the whole run; a hung handshake lands here.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Drive one item and hold start until the block takes it. Insert a random
    // idle burst first when idling is enabled. Start stays high after the
    // accepting edge; the next call or wait_drained drives it again.
    task automatic issue(logic [1:0] cmd, logic [63:0] ns);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            idle_left = $urandom_range(1, 11);
            start        <= 1'b0;
            i_latency_ns <= {$urandom, $urandom};
            repeat (idle_left) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_latency_ns <= ns;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Hold off until every expected summary has arrived.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (summaries_pending != 0) @(posedge i_clk);
    endtask

    // Pick a latency whose microsecond value lands in a chosen bucket, with
    // occasional full-range noise so the top bit patterns are reached too.
    function automatic logic [63:0] pick_latency();
        int b;
        logic [63:0] us;
        if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
        b = $urandom_range(0, NUM_BUCKETS + 2);
        us = (64'd1 << b) | ({$urandom, $urandom} & ((64'd1 << b) - 1));
        if ($urandom_range(0, 9) == 0) us = 0;
        return us * 64'd1000 + $urandom_range(0, 999);
    endfunction

    initial begin
        logic [1:0]  cmd;
        int          pick;
        start        = 1'b0;
        i_cmd        = CMD_RECORD;
        i_latency_ns = '0;
        idle_enable  = 1'b0;
        i_rst_n      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty summary, bucket edges, extremes, unused command, clear.
        issue(CMD_SUMMARIZE, '0);
        issue(CMD_RECORD, 64'd0);
        issue(CMD_RECORD, 64'd999);
        issue(CMD_RECORD, 64'd1999);
        issue(CMD_RECORD, 64'd2000);
        issue(CMD_SUMMARIZE, '0);
        issue(CMD_RECORD, ALL_ONES);
        issue(CMD_RECORD, 64'd65536000);
        issue(CMD_RECORD, 64'd32768000 - 1);
        issue(CMD_UNUSED, 64'd5000);
        issue(CMD_SUMMARIZE, '0);
        issue(CMD_CLEAR, ALL_ONES);
        issue(CMD_SUMMARIZE, '0);
        // single huge sample: sum at the top, all bounds in the last bucket
        issue(CMD_RECORD, ALL_ONES);
        issue(CMD_SUMMARIZE, '0);
        // wrap the sum
        issue(CMD_RECORD, 64'h8000_0000_0000_0000);
        issue(CMD_RECORD, 64'h8000_0000_0000_0001);
        issue(CMD_SUMMARIZE, '0);
        issue(CMD_CLEAR, '0);
        wait_drained();

        // Random part: mostly records, occasional summary, rare clear/unused.
        idle_enable = 1'b1;
        for (int n = 0; n < 450; n++) begin
            if (n == 380) idle_enable = 1'b0;
            if (n == 200) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 82)      cmd = CMD_RECORD;
            else if (pick < 94) cmd = CMD_SUMMARIZE;
            else if (pick < 97) cmd = CMD_CLEAR;
            else                cmd = CMD_UNUSED;
            issue(cmd, pick_latency());
        end
        issue(CMD_SUMMARIZE, '0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lhist_pkg.sv
sv/lhist_div.sv
sv/lhist_ctrl.sv
sv/lhist_dp.sv
sv/log2_latency_histogram_core.sv
tb/lhist_checker.sv
tb/tb_log2_latency_histogram_core.sv
